// ----- sv/vtg_pkg.sv -----
// Package for the voxel tag grid: types and constants.
package vtg_pkg;

    localparam int GridX = 32;
    localparam int GridY = 32;
    localparam int GridZ = 32;
    localparam int AddrBits = 15;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_PEC   = 3'd2,
        OP_PMC   = 3'd3,
        OP_CHECK = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] x_lo;
        logic [4:0] y_lo;
        logic [4:0] z_lo;
        logic [4:0] x_hi;
        logic [4:0] y_hi;
        logic [4:0] z_hi;
        logic [7:0] tag_in;
    } in_word_t;

    typedef struct packed {
        logic       is_check;
        logic [7:0] tag_out;
        logic [8:0] sym_matrix;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Memory port request from the sequencer.
    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [AddrBits-1:0] addr;
        logic [7:0]          wdata;
    } mem_req_t;

endpackage

// ----- sv/voxel_tag_grid_symmetry_engine.sv -----
// Top level of the voxel tag grid: sequencer around one tag memory.
//
// Input words arrive on in_word with in_valid, and are taken when in_stall is
// low. Results leave on out_word with out_valid and are taken when out_stall
// is low. Only voxel reads and symmetry checks produce a result word.
//
// After reset the block sweeps the 32768-entry memory to zero, one entry per
// cycle, and holds in_stall high until the sweep is done.
//
// A voxel write or an unused op leaves the block idle. A cube fill writes
// its 27 voxels one per cycle after the accepting edge. A voxel read goes
// through the drain state, which raises out_valid. A symmetry check walks
// the box with at most one memory read per cycle over nine passes, a face
// pass and two side passes per axis, and then goes through the drain state
// to raise out_valid. All of this shares the single memory port.
//
// One item is worked on at a time. A result waits in the output register
// while out_stall is high, and in_stall stays high until it leaves.
module voxel_tag_grid_symmetry_engine
    import vtg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    state_t state_reg, state_next;
    in_word_t cmd_reg, cmd_next;
    logic [AddrBits-1:0] clr_reg, clr_next;
    logic [1:0] fd0_reg, fd0_next, fd1_reg, fd1_next, fd2_reg, fd2_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] pass_reg, pass_next;        // 0 face, 1 side s=c, 2 side s=b
    logic [5:0] i1_reg, i1_next, i2_reg, i2_next;
    logic [1:0] ph_reg, ph_next;            // read phase inside one step
    logic [7:0] m1_reg, m1_next, m2_reg, m2_next, t1_reg, t1_next;
    logic [8:0] mat_reg, mat_next;
    logic ok_reg, ok_next;
    logic pend_reg, pend_next;              // a read is in flight
    logic pin_reg, pin_next;                // that read is inside the grid
    logic [1:0] pdst_reg, pdst_next;
    out_word_t ow_reg, ow_next;
    logic ov_reg, ov_next;
    mem_req_t req;
    logic [7:0] rdata, rval;

    vtg_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

    assign rval = pin_reg ? rdata : 8'd0;

    // Signed box extents, range -30..32.
    logic signed [6:0] n [3];
    logic signed [6:0] lo [3];
    always_comb
    begin
        lo[0] = {2'b00, cmd_reg.x_lo};
        lo[1] = {2'b00, cmd_reg.y_lo};
        lo[2] = {2'b00, cmd_reg.z_lo};
        n[0] = $signed({2'b00, cmd_reg.x_hi}) - lo[0] + 7'sd1;
        n[1] = $signed({2'b00, cmd_reg.y_hi}) - lo[1] + 7'sd1;
        n[2] = $signed({2'b00, cmd_reg.z_hi}) - lo[2] + 7'sd1;
    end

    function automatic logic [1:0] nxt(input logic [1:0] a);
        nxt = (a == 2'd2) ? 2'd0 : a + 2'd1;
    endfunction

    // Axis roles for the current pass.
    logic [1:0] ax_b, ax_c, ax_s, ax_w;
    always_comb
    begin
        ax_b = nxt(axis_reg);
        ax_c = nxt(ax_b);
        ax_s = (pass_reg == 2'd1) ? ax_c : ax_b;
        ax_w = (pass_reg == 2'd1) ? ax_b : ax_c;
    end

    // Read address generator: offsets added to the box corner.
    logic signed [7:0] off [3];
    logic signed [7:0] pos [3];
    logic pos_in;
    logic [AddrBits-1:0] pos_addr;
    always_comb
    begin
        pos_in = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            pos[k] = {lo[k][6], lo[k]} + off[k];
            if (pos[k] < 8'sd0 || pos[k] > 8'sd31)
            begin
                pos_in = 1'b0;
            end
        end
        pos_addr = {pos[2][4:0], pos[1][4:0], pos[0][4:0]};
    end

    // Cube fill address; the three digit counters step through the cube.
    logic [4:0] fx, fy, fz;
    logic [4:0] base_sub;
    always_comb
    begin
        base_sub = (cmd_reg.op == OP_PMC) ? 5'd1 : 5'd0;
        fx = {cmd_reg.x_lo[3:0], 1'b0} + {3'd0, fd0_reg} - base_sub;
        fy = {cmd_reg.y_lo[3:0], 1'b0} + {3'd0, fd1_reg} - base_sub;
        fz = {cmd_reg.z_lo[3:0], 1'b0} + {3'd0, fd2_reg} - base_sub;
    end

    logic signed [6:0] lim1, lim2;
    logic bad;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        clr_next = clr_reg;
        fd0_next = fd0_reg;
        fd1_next = fd1_reg;
        fd2_next = fd2_reg;
        axis_next = axis_reg;
        pass_next = pass_reg;
        i1_next = i1_reg;
        i2_next = i2_reg;
        ph_next = ph_reg;
        m1_next = m1_reg;
        m2_next = m2_reg;
        t1_next = t1_reg;
        mat_next = mat_reg;
        ok_next = ok_reg;
        pend_next = 1'b0;
        pin_next = 1'b0;
        pdst_next = ph_reg;
        ow_next = ow_reg;
        ov_next = ov_reg;
        req = '0;
        in_stall = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            off[k] = 8'sd0;
        end
        lim1 = 7'sd0;
        lim2 = 7'sd0;
        bad = 1'b0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        // Consume a returning scan read.
        if (pend_reg)
        begin
            case (pdst_reg)
                2'd0: t1_next = rval;
                2'd1:
                begin
                    if (pass_reg == 2'd0)
                    begin
                        if (t1_reg != rval)
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        m1_next = rval;
                    end
                end
                2'd2: m2_next = rval;
                default:
                begin
                    if (rval != m2_reg)
                    begin
                        ok_next = 1'b0;
                    end
                end
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                req.wr = 1'b1;
                req.addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = ov_reg;
                if (in_valid && !ov_reg)
                begin
                    cmd_next = in_word;
                    case (in_word.op)
                        OP_WRITE:
                        begin
                            req.wr = 1'b1;
                            req.addr = {in_word.z_lo, in_word.y_lo, in_word.x_lo};
                            req.wdata = in_word.tag_in;
                        end
                        OP_READ:
                        begin
                            req.rd = 1'b1;
                            req.addr = {in_word.z_lo, in_word.y_lo, in_word.x_lo};
                            state_next = ST_DRAIN;
                            ph_next = 2'd0;
                        end
                        OP_PEC, OP_PMC:
                        begin
                            fd0_next = 2'd0;
                            fd1_next = 2'd0;
                            fd2_next = 2'd0;
                            state_next = ST_FILL;
                        end
                        OP_CHECK:
                        begin
                            axis_next = 2'd0;
                            pass_next = 2'd0;
                            i1_next = 6'd0;
                            i2_next = 6'd0;
                            ph_next = 2'd0;
                            ok_next = 1'b1;
                            mat_next = 9'd0;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL:
            begin
                req.wr = 1'b1;
                req.addr = {fz, fy, fx};
                req.wdata = cmd_reg.tag_in;
                if (fd2_reg == 2'd2)
                begin
                    fd2_next = 2'd0;
                    if (fd1_reg == 2'd2)
                    begin
                        fd1_next = 2'd0;
                        if (fd0_reg == 2'd2)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            fd0_next = fd0_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        fd1_next = fd1_reg + 2'd1;
                    end
                end
                else
                begin
                    fd2_next = fd2_reg + 2'd1;
                end
            end
            ST_SCAN:
            begin
                // Outer loop i1, inner loop i2, with a read phase per step.
                if (pass_reg == 2'd0)
                begin
                    lim1 = n[ax_b];
                    lim2 = n[ax_c];
                end
                else
                begin
                    lim1 = n[ax_s] - 7'sd1;
                    lim2 = n[axis_reg] - 7'sd1;
                end
                if ($signed({1'b0, i1_reg}) >= lim1)
                begin
                    // Pass done: record it and move on.
                    if (!pend_reg)
                    begin
                        if (ok_reg)
                        begin
                            if (pass_reg == 2'd0)
                            begin
                                mat_next[axis_reg * 3 + axis_reg] = 1'b1;
                            end
                            else if (pass_reg == 2'd1)
                            begin
                                mat_next[axis_reg * 3 + ax_b] = 1'b1;
                            end
                            else
                            begin
                                mat_next[axis_reg * 3 + ax_c] = 1'b1;
                            end
                        end
                        ok_next = 1'b1;
                        i1_next = 6'd0;
                        i2_next = 6'd0;
                        ph_next = 2'd0;
                        if (pass_reg == 2'd2)
                        begin
                            pass_next = 2'd0;
                            axis_next = nxt(axis_reg);
                            if (axis_reg == 2'd2)
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        else
                        begin
                            pass_next = pass_reg + 2'd1;
                        end
                    end
                end
                else if (pass_reg == 2'd0)
                begin
                    if ($signed({1'b0, i2_reg}) >= lim2)
                    begin
                        i2_next = 6'd0;
                        i1_next = i1_reg + 6'd1;
                    end
                    else
                    begin
                        off[ax_b] = {2'b00, i1_reg};
                        off[ax_c] = {2'b00, i2_reg};
                        if (ph_reg == 2'd1)
                        begin
                            off[axis_reg] = {n[axis_reg][6], n[axis_reg]} - 8'sd1;
                        end
                        req.rd = pos_in;
                        req.addr = pos_addr;
                        pend_next = 1'b1;
                        pin_next = pos_in;
                        pdst_next = ph_reg;
                        if (ph_reg == 2'd1)
                        begin
                            ph_next = 2'd0;
                            i2_next = i2_reg + 6'd1;
                        end
                        else
                        begin
                            ph_next = 2'd1;
                        end
                    end
                end
                else
                begin
                    // Side pass: phase 1 reads m1, 2 reads m2, then per ii
                    // phase 0 reads q1 (into t1 via m-compare) and 3 reads q2.
                    off[ax_s] = {2'b00, i1_reg};
                    if (ph_reg == 2'd2 || ph_reg == 2'd3)
                    begin
                        off[ax_w] = {n[ax_w][6], n[ax_w]} - 8'sd1;
                    end
                    if (i2_reg != 6'd0)
                    begin
                        off[axis_reg] = {2'b00, i2_reg} - 8'sd1;
                    end
                    if (i2_reg == 6'd0)
                    begin
                        // Fetch the two ray heads.
                        req.rd = pos_in;
                        req.addr = pos_addr;
                        pend_next = 1'b1;
                        pin_next = pos_in;
                        if (ph_reg == 2'd2)
                        begin
                            pdst_next = 2'd2;
                            ph_next = 2'd0;
                            i2_next = 6'd1;
                        end
                        else
                        begin
                            off[ax_w] = 8'sd0;
                            pdst_next = 2'd1;
                            ph_next = 2'd2;
                        end
                    end
                    else if ($signed({1'b0, i2_reg}) > lim2)
                    begin
                        if (!pend_reg)
                        begin
                            i2_next = 6'd0;
                            ph_next = 2'd1;
                            i1_next = i1_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        req.rd = pos_in;
                        req.addr = pos_addr;
                        pend_next = 1'b1;
                        pin_next = pos_in;
                        if (ph_reg == 2'd3)
                        begin
                            pdst_next = 2'd3;
                            ph_next = 2'd0;
                            i2_next = i2_reg + 6'd1;
                        end
                        else
                        begin
                            pdst_next = 2'd0;
                            ph_next = 2'd3;
                        end
                    end
                    if (ph_reg == 2'd0 && i2_reg == 6'd0)
                    begin
                        ph_next = 2'd2;
                    end
                end
                // q1 compare against m1 happens when q2 is issued.
                if (pend_reg && pdst_reg == 2'd0 && pass_reg != 2'd0)
                begin
                    bad = (rval != m1_reg);
                    if (bad)
                    begin
                        ok_next = 1'b0;
                    end
                end
            end
            ST_DRAIN:
            begin
                // The output register is always empty here, since a word is
                // only taken while it is empty.
                ov_next = 1'b1;
                state_next = ST_IDLE;
                if (cmd_reg.op == OP_READ)
                begin
                    ow_next.is_check = 1'b0;
                    ow_next.tag_out = rdata;
                    ow_next.sym_matrix = 9'd0;
                end
                else
                begin
                    ow_next.is_check = 1'b1;
                    ow_next.tag_out = 8'd0;
                    ow_next.sym_matrix = mat_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ov_reg <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        fd0_reg <= fd0_next;
        fd1_reg <= fd1_next;
        fd2_reg <= fd2_next;
        axis_reg <= axis_next;
        pass_reg <= pass_next;
        i1_reg <= i1_next;
        i2_reg <= i2_next;
        ph_reg <= ph_next;
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        t1_reg <= t1_next;
        mat_reg <= mat_next;
        ok_reg <= ok_next;
        pin_reg <= pin_next;
        pdst_reg <= pdst_next;
        ow_reg <= ow_next;
    end

    assign out_valid = ov_reg;
    assign out_word = ow_reg;

endmodule

// ----- sv/vtg_ram.sv -----
// Single-port tag memory with a registered read.
module vtg_ram
    import vtg_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [0:(1 << AddrBits) - 1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/vtg_checker.sv -----
// Checker for the voxel tag grid: watches both channels, predicts results and compares them.
module vtg_checker
    import vtg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_word,
    output int        fail_count,
    output int        pending_count,
    output int        read_count,
    output int        check_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] grid_model [0:32767];
    out_word_t  expected_words [$];

    // Positions are signed because box extents can go negative.
    function automatic logic [7:0] tag_at(int px, int py, int pz);
        if (px < 0 || px >= GridX || py < 0 || py >= GridY || pz < 0 || pz >= GridZ)
            return 8'd0;
        return grid_model[px + GridX * (py + GridY * pz)];
    endfunction

    function automatic logic [7:0] tag_vec(int p[3]);
        return tag_at(p[0], p[1], p[2]);
    endfunction

    function automatic bit rays_constant(int o[3], int n[3], int a, int s, int w);
        bit ok;
        int p1[3];
        int p2[3];
        int q1[3];
        int q2[3];
        logic [7:0] m1;
        logic [7:0] m2;
        ok = 1;
        for (int t = 0; t < n[s] - 1; t++)
        begin
            p1 = o;
            p1[s] += t;
            p2 = p1;
            p2[w] += n[w] - 1;
            m1 = tag_vec(p1);
            m2 = tag_vec(p2);
            for (int ii = 0; ii < n[a] - 1; ii++)
            begin
                q1 = p1;
                q2 = p2;
                q1[a] += ii;
                q2[a] += ii;
                if (tag_vec(q1) != m1 || tag_vec(q2) != m2)
                    ok = 0;
            end
        end
        return ok;
    endfunction

    function automatic logic [8:0] box_symmetry(in_word_t w);
        logic [8:0] m;
        int o[3];
        int n[3];
        int p[3];
        int q[3];
        int b;
        int c;
        bit face;
        m = '0;
        o = '{int'(w.x_lo), int'(w.y_lo), int'(w.z_lo)};
        n[0] = int'(w.x_hi) - o[0] + 1;
        n[1] = int'(w.y_hi) - o[1] + 1;
        n[2] = int'(w.z_hi) - o[2] + 1;
        for (int a = 0; a < 3; a++)
        begin
            b = (a + 1) % 3;
            c = (a + 2) % 3;
            face = 1;
            for (int jj = 0; jj < n[b]; jj++)
                for (int kk = 0; kk < n[c]; kk++)
                begin
                    p = o;
                    p[b] += jj;
                    p[c] += kk;
                    q = p;
                    q[a] += n[a] - 1;
                    if (tag_vec(p) != tag_vec(q))
                        face = 0;
                end
            if (face)
                m[a * 3 + a] = 1'b1;
            if (rays_constant(o, n, a, c, b))
                m[a * 3 + b] = 1'b1;
            if (rays_constant(o, n, a, b, c))
                m[a * 3 + c] = 1'b1;
        end
        return m;
    endfunction

    task automatic fill_cube(in_word_t w, int first);
        int px;
        int py;
        int pz;
        for (int d0 = 0; d0 < 3; d0++)
            for (int d1 = 0; d1 < 3; d1++)
                for (int d2 = 0; d2 < 3; d2++)
                begin
                    px = (2 * int'(w.x_lo) + first + d0 + GridX) % GridX;
                    py = (2 * int'(w.y_lo) + first + d1 + GridY) % GridY;
                    pz = (2 * int'(w.z_lo) + first + d2 + GridZ) % GridZ;
                    grid_model[px + GridX * (py + GridY * pz)] = w.tag_in;
                end
    endtask

    task automatic apply_word(in_word_t w);
        out_word_t r;
        r = '0;
        case (w.op)
            OP_WRITE: grid_model[{w.z_lo, w.y_lo, w.x_lo}] = w.tag_in;
            OP_READ:
            begin
                r.tag_out = tag_at(int'(w.x_lo), int'(w.y_lo), int'(w.z_lo));
                expected_words.push_back(r);
                read_count++;
            end
            OP_PEC: fill_cube(w, 0);
            OP_PMC: fill_cube(w, -1);
            OP_CHECK:
            begin
                r.is_check = 1'b1;
                r.sym_matrix = box_symmetry(w);
                expected_words.push_back(r);
                check_count++;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        for (int i = 0; i < 32768; i++)
            grid_model[i] = 8'd0;
        fail_count = 0;
        pending_count = 0;
        read_count = 0;
        check_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Compare the result first; a word accepted at the same edge cannot affect it.
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%t: unexpected result word, expected none, got %h",
                             $realtime, out_word);
                    fail_count++;
                end
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (e.is_check !== out_word.is_check ||
                        e.tag_out !== out_word.tag_out ||
                        e.sym_matrix !== out_word.sym_matrix)
                    begin
                        $display("%t: mismatch expected chk=%0d tag=%h sym=%b",
                                 $realtime, e.is_check, e.tag_out, e.sym_matrix,
                                 " got chk=%0d tag=%h sym=%b",
                                 out_word.is_check, out_word.tag_out, out_word.sym_matrix);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_word(in_word);
            pending_count = expected_words.size();
        end
    end
endmodule

// ----- tb/tb_voxel_tag_grid_symmetry_engine.sv -----
// Testbench top for the voxel tag grid: stimulus, idling and the final verdict.
module tb_voxel_tag_grid_symmetry_engine;
    import vtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    int        fail_count;
    int        pending_count;
    int        read_count;
    int        check_count;
    int        idle_cycles;

    // The limit leaves ample room for the memory clear after reset and for a
    // check of the whole grid.
    localparam int WatchdogLimit = 200000;

    voxel_tag_grid_symmetry_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    vtg_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .fail_count(fail_count), .pending_count(pending_count),
        .read_count(read_count), .check_count(check_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Draws a gap length; about one word in four runs with no gap at all.
    function automatic int gap_len();
        if ($urandom_range(3) == 0)
            return 0;
        return $urandom_range(19);
    endfunction

    // Sends one word, waiting a random gap first and holding it until accepted.
    // Called at a falling edge and returns at a falling edge with valid still high.
    task automatic send_word(in_word_t w);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_word_t make_word(op_t op, int xl, int yl, int zl,
                                           int xh, int yh, int zh, int tag);
        in_word_t w;
        w.op = op;
        w.x_lo = 5'(xl);
        w.y_lo = 5'(yl);
        w.z_lo = 5'(zl);
        w.x_hi = 5'(xh);
        w.y_hi = 5'(yh);
        w.z_hi = 5'(zh);
        w.tag_in = 8'(tag);
        return w;
    endfunction

    function automatic in_word_t random_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_word_t)-1:0];
    endfunction

    // A check box spans a few voxels per axis and is sometimes inverted; a high
    // end that would run past the grid edge wraps around to a low index instead.
    function automatic in_word_t random_check();
        in_word_t w;
        w = random_word();
        w.op = OP_CHECK;
        w.x_hi = 5'(w.x_lo + $urandom_range(5) - ($urandom_range(7) == 0 ? 6 : 0));
        w.y_hi = 5'(w.y_lo + $urandom_range(5) - ($urandom_range(7) == 0 ? 6 : 0));
        w.z_hi = 5'(w.z_lo + $urandom_range(5) - ($urandom_range(7) == 0 ? 6 : 0));
        return w;
    endfunction

    // Receiver side: stalls for a random gap before each result word.
    initial
    begin
        int gap;
        out_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            gap = gap_len();
            if (gap == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // The watchdog restarts whenever a word moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("tb_voxel_tag_grid_symmetry_engine: done, errors");
            $finish;
        end
    end

    initial
    begin
        in_word_t w;
        int sel;
        int bx;
        int by;
        int bz;
        idle_cycles = 0;
        in_valid = 1'b0;
        in_word = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reads of a cleared grid, corner writes, both fills at the
        // wrapping corner, inverted and single-voxel boxes, and unused ops.
        send_word(make_word(OP_READ, 31, 31, 31, 0, 0, 0, 0));
        send_word(make_word(OP_CHECK, 0, 0, 0, 31, 31, 31, 0));
        send_word(make_word(OP_WRITE, 0, 0, 0, 0, 0, 0, 255));
        send_word(make_word(OP_WRITE, 31, 31, 31, 0, 0, 0, 170));
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_READ, 31, 31, 31, 0, 0, 0, 0));
        send_word(make_word(OP_PEC, 15, 15, 15, 0, 0, 0, 85));
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_READ, 30, 31, 0, 0, 0, 0, 0));
        send_word(make_word(OP_PMC, 0, 0, 0, 0, 0, 0, 1));
        send_word(make_word(OP_READ, 31, 31, 31, 0, 0, 0, 0));
        send_word(make_word(OP_READ, 1, 0, 31, 0, 0, 0, 0));
        send_word(make_word(OP_CHECK, 29, 29, 29, 31, 31, 31, 0));
        send_word(make_word(OP_CHECK, 30, 30, 30, 4, 4, 4, 0));
        send_word(make_word(OP_CHECK, 5, 5, 5, 5, 5, 5, 0));
        send_word(make_word(OP_CHECK, 31, 0, 31, 0, 2, 31, 0));
        send_word(make_word(OP_PEC, 3, 3, 3, 0, 0, 0, 7));
        send_word(make_word(OP_CHECK, 6, 6, 6, 8, 8, 8, 0));
        send_word(make_word(OP_CHECK, 5, 6, 6, 9, 8, 8, 0));
        send_word(in_word_t'({3'd5, 38'h3F_FFFF_FFFF}));
        send_word(in_word_t'({3'd7, 38'h00_0000_0000}));
        send_word(make_word(OP_CHECK, 0, 0, 0, 31, 31, 31, 255));

        // Random part: work in a small region so checks see structure, with
        // occasional fully random words for coverage of every field bit.
        repeat (1030)
        begin
            bx = $urandom_range(3) * 8;
            by = $urandom_range(3) * 8;
            bz = $urandom_range(3) * 8;
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                w = random_word();
                if (w.op == OP_CHECK)
                    w = random_check();
            end
            else if (sel < 35)
                w = make_word(OP_WRITE, bx + $urandom_range(7), by + $urandom_range(7),
                              bz + $urandom_range(7), $urandom_range(31),
                              $urandom_range(31), $urandom_range(31), $urandom_range(3));
            else if (sel < 60)
                w = make_word(OP_READ, $urandom_range(31), $urandom_range(31),
                              $urandom_range(31), $urandom_range(31), 0, 0, 0);
            else if (sel < 75)
                w = make_word($urandom_range(1) ? OP_PEC : OP_PMC, $urandom_range(15),
                              $urandom_range(15), $urandom_range(15), 0, 0, 0,
                              $urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
            else
            begin
                w = random_check();
                if ($urandom_range(1))
                begin
                    w.x_lo = 5'(bx + $urandom_range(3));
                    w.y_lo = 5'(by + $urandom_range(3));
                    w.z_lo = 5'(bz + $urandom_range(3));
                    w.x_hi = 5'(w.x_lo + $urandom_range(4));
                    w.y_hi = 5'(w.y_lo + $urandom_range(4));
                    w.z_hi = 5'(w.z_lo + $urandom_range(4));
                end
            end
            send_word(w);
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d voxel reads and %0d symmetry checks among 1052 words,",
                 read_count, check_count);
        $display("with writes, both cube fills and unused ops interleaved under random gaps.");
        if (fail_count == 0)
            $display("tb_voxel_tag_grid_symmetry_engine: done, clean");
        else
            $display("tb_voxel_tag_grid_symmetry_engine: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/vtg_pkg.sv
sv/vtg_ram.sv
sv/voxel_tag_grid_symmetry_engine.sv
tb/vtg_checker.sv
tb/tb_voxel_tag_grid_symmetry_engine.sv
